/* hw/rtl/gsr_pkg.sv */
`default_nettype none
package gsr_pkg;

    localparam int MAX_ROWS = 64;
    localparam int ADDR_W   = $clog2(MAX_ROWS);
    localparam int CNT_W    = $clog2(MAX_ROWS + 1);
    localparam int ROW_W    = 51;
    localparam int RANK_W   = 8;

    localparam logic [2:0] CFG_ASCENDING = 3'd0;
    localparam logic [2:0] CFG_USE_STAT  = 3'd1;
    localparam logic [2:0] CFG_USE_CAT   = 3'd2;
    localparam logic [2:0] CFG_RANK_EN   = 3'd3;
    localparam logic [2:0] CFG_KEEP_NEG  = 3'd4;

    localparam logic [1:0] CLASS_NONCOMP = 2'd1;
    localparam logic [1:0] CLASS_NEG     = 2'd2;

    typedef struct packed {
        logic [5:0]         tag;
        logic [1:0]         rclass;
        logic signed [31:0] score;
        logic [2:0]         status;
        logic [7:0]         category;
    } t_row;

    typedef struct packed {
        logic ascending;
        logic use_status;
        logic use_category;
        logic rank_enable;
        logic keep_negative;
    } t_cfg;

    function automatic logic goes_after(t_row a, t_row b, t_cfg c);
        logic r;
        if (c.use_category && a.category != b.category) begin
            r = a.category > b.category;
        end else if (c.use_status && a.status != b.status) begin
            r = a.status > b.status;
        end else if (c.ascending) begin
            r = a.score > b.score;
        end else begin
            r = a.score < b.score;
        end
        return r;
    endfunction

    function automatic logic key_equal(t_row a, t_row b, t_cfg c);
        return (!c.use_category || a.category == b.category) &&
               (!c.use_status || a.status == b.status) && (a.score == b.score);
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/gsr_ram.sv */
`default_nettype none
module gsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* hw/rtl/gsr_ranker.sv */
`default_nettype none
module gsr_ranker
    import gsr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_clear,
    input  wire logic              i_step,
    input  wire t_row              i_row,
    input  wire t_cfg              i_cfg,
    output logic [RANK_W-1:0]      o_rank,
    output logic                   o_ranked
);
    logic               r_started, n_started;
    logic [7:0]         r_cur_cat, n_cur_cat;
    logic signed [31:0] r_cur_val, n_cur_val;
    logic [RANK_W-1:0]  r_cur_rank, n_cur_rank;
    logic [RANK_W-1:0]  r_step, n_step;
    logic               pass;
    logic [7:0]         cat;
    logic [RANK_W-1:0]  rank_now;
    logic [RANK_W-1:0]  step_now;

    always_comb begin
        pass = (i_row.rclass == CLASS_NONCOMP) ||
               (i_cfg.keep_negative && i_row.rclass == CLASS_NEG);
        cat  = i_cfg.use_category ? i_row.category : 8'd0;
        n_started  = r_started;
        n_cur_cat  = r_cur_cat;
        n_cur_val  = r_cur_val;
        n_cur_rank = r_cur_rank;
        n_step     = r_step;
        rank_now   = r_cur_rank;
        step_now   = r_step;
        o_rank     = '0;
        o_ranked   = 1'b0;
        if (i_cfg.rank_enable && !pass) begin
            if (!r_started || cat != r_cur_cat) begin
                rank_now = RANK_W'(1);
                step_now = RANK_W'(1);
            end else if (i_row.score == r_cur_val) begin
                rank_now = r_cur_rank - r_step;
                step_now = r_step + RANK_W'(1);
            end else begin
                step_now = RANK_W'(1);
            end
            o_rank   = (i_cfg.use_status && i_row.status != 3'd0) ? '1 : rank_now;
            o_ranked = 1'b1;
            n_started  = 1'b1;
            n_cur_cat  = cat;
            n_cur_val  = i_row.score;
            n_cur_rank = rank_now + step_now;
            n_step     = step_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_started <= 1'b0;
        end else if (i_step) begin
            r_started <= n_started;
        end
        if (i_step) begin
            r_cur_cat  <= n_cur_cat;
            r_cur_val  <= n_cur_val;
            r_cur_rank <= n_cur_rank;
            r_step     <= n_step;
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/grouped_sort_and_rank_core.sv */
`default_nettype none
// Rows enter on the slave stream, one item per cycle, and are written into a
// 64-entry row memory. The item with tlast set ends the data set; a row that
// arrives while 64 rows are stored is dropped, but its tlast still counts.
// The block then stops taking items and finds each row's sorted position by
// comparing it with every stored row, one memory read per cycle; the positions
// fill an order memory. Rows then leave on the master stream in sorted order
// with their rank; each result item reads its index from the order memory,
// then its row from the row memory, and is ranked into the output register;
// a stalled receiver simply holds the item in the output register.
// After the final item (master tlast) the block takes input again.
// Configuration is to be written through the plain write port only while idle; the block itself does not enforce this.
// Reset empties the row store and sets the configuration to its defaults.
module grouped_sort_and_rank_core
    import gsr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [0:0]  i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // category_number, status_code, score_value, rank_class, row_tag, 5 zero bits
    input  wire logic [55:0] s_axis_tdata,
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // out_tag, out_category, out_status, out_score, out_rank, out_ranked, 6 zero bits
    output logic [63:0]      m_axis_tdata,
    output logic             m_axis_tlast
);
    localparam logic [3:0] S_LOAD   = 4'd0;
    localparam logic [3:0] S_FETCH  = 4'd1;
    localparam logic [3:0] S_LATCH  = 4'd2;
    localparam logic [3:0] S_SCAN   = 4'd3;
    localparam logic [3:0] S_DRAIN  = 4'd4;
    localparam logic [3:0] S_WR     = 4'd5;
    localparam logic [3:0] S_OFETCH = 4'd6;
    localparam logic [3:0] S_OWAIT1 = 4'd7;
    localparam logic [3:0] S_OWAIT2 = 4'd8;
    localparam logic [3:0] S_OSEND  = 4'd9;

    logic [3:0]       r_state;
    t_cfg             r_cfg;
    logic [CNT_W-1:0] r_cnt, r_n, r_i, r_j, r_pos, r_k;
    logic [ADDR_W-1:0] r_jd;
    logic             r_dv;
    t_row             r_row_i;
    logic [57:0]      r_out;
    logic             r_out_last;

    logic              row_we;
    logic [ADDR_W-1:0] row_raddr;
    t_row              row_rdata;
    logic [ROW_W-1:0]  row_rbits;
    logic [ADDR_W-1:0] ord_rdata;
    logic              in_acc, full;
    t_row              in_row;
    logic [RANK_W-1:0] rank;
    logic              ranked;

    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign full   = (r_cnt == CNT_W'(MAX_ROWS));
    assign row_we = in_acc && !full;
    assign in_row = t_row'(s_axis_tdata[ROW_W-1:0]);
    assign row_rdata = t_row'(row_rbits);

    assign s_axis_tready = (r_state == S_LOAD);
    assign m_axis_tvalid = (r_state == S_OSEND);
    assign m_axis_tdata  = {6'd0, r_out};
    assign m_axis_tlast  = r_out_last;

    always_comb begin
        unique case (r_state)
            S_FETCH:  row_raddr = r_i[ADDR_W-1:0];
            S_SCAN:   row_raddr = r_j[ADDR_W-1:0];
            default:  row_raddr = ord_rdata;
        endcase
    end

    gsr_ram #(.WIDTH(ROW_W), .DEPTH(MAX_ROWS)) u_rows (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (r_cnt[ADDR_W-1:0]),
        .i_wdata (ROW_W'(in_row)),
        .i_raddr (row_raddr),
        .o_rdata (row_rbits)
    );

    gsr_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_ROWS)) u_order (
        .i_clk   (i_clk),
        .i_we    (r_state == S_WR),
        .i_waddr (r_pos[ADDR_W-1:0]),
        .i_wdata (r_i[ADDR_W-1:0]),
        .i_raddr (r_k[ADDR_W-1:0]),
        .o_rdata (ord_rdata)
    );

    gsr_ranker u_ranker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (r_state == S_FETCH),
        .i_step   (r_state == S_OWAIT2),
        .i_row    (row_rdata),
        .i_cfg    (r_cfg),
        .o_rank   (rank),
        .o_ranked (ranked)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_dv    <= 1'b0;
            r_cfg   <= '{ascending: 1'b1, use_status: 1'b1, use_category: 1'b1,
                         rank_enable: 1'b1, keep_negative: 1'b0};
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_ASCENDING: r_cfg.ascending     <= i_cfg_data[0];
                    CFG_USE_STAT:  r_cfg.use_status    <= i_cfg_data[0];
                    CFG_USE_CAT:   r_cfg.use_category  <= i_cfg_data[0];
                    CFG_RANK_EN:   r_cfg.rank_enable   <= i_cfg_data[0];
                    CFG_KEEP_NEG:  r_cfg.keep_negative <= i_cfg_data[0];
                    default: ;
                endcase
            end
            r_dv <= (r_state == S_SCAN) && (r_j < r_n);
            r_jd <= r_j[ADDR_W-1:0];
            if (r_dv) begin
                if (goes_after(r_row_i, row_rdata, r_cfg) ||
                    (key_equal(r_row_i, row_rdata, r_cfg) &&
                     CNT_W'(r_jd) < r_i)) begin
                    r_pos <= r_pos + CNT_W'(1);
                end
            end
            unique case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        if (!full) begin
                            r_cnt <= r_cnt + CNT_W'(1);
                        end
                        if (s_axis_tlast) begin
                            r_n     <= full ? r_cnt : r_cnt + CNT_W'(1);
                            r_i     <= '0;
                            r_state <= S_FETCH;
                        end
                    end
                end
                S_FETCH: r_state <= S_LATCH;
                S_LATCH: begin
                    r_row_i <= row_rdata;
                    r_j     <= '0;
                    r_pos   <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_j < r_n) begin
                        r_j <= r_j + CNT_W'(1);
                    end else begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: r_state <= S_WR;
                S_WR: begin
                    r_i <= r_i + CNT_W'(1);
                    if (r_i + CNT_W'(1) == r_n) begin
                        r_k     <= '0;
                        r_state <= S_OFETCH;
                    end else begin
                        r_state <= S_FETCH;
                    end
                end
                S_OFETCH: r_state <= S_OWAIT1;
                S_OWAIT1: r_state <= S_OWAIT2;
                S_OWAIT2: begin
                    r_out <= {ranked, rank, row_rdata.score, row_rdata.status,
                              row_rdata.category, row_rdata.tag};
                    r_out_last <= (r_k + CNT_W'(1) == r_n);
                    r_state    <= S_OSEND;
                end
                S_OSEND: begin
                    if (m_axis_tready) begin
                        r_k <= r_k + CNT_W'(1);
                        if (r_out_last) begin
                            r_cnt   <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_state <= S_OFETCH;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end
endmodule
`default_nettype wire

/* test/grouped_sort_and_rank_core_test.sv */
`timescale 1ns / 100ps

module grouped_sort_and_rank_core_test;
    import gsr_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE = 40;

    typedef struct {
        t_row row;
        logic last;
    } t_load;

    typedef struct {
        logic [5:0]  tag;
        logic [7:0]  category;
        logic [2:0]  status;
        logic [31:0] score;
        logic [7:0]  rank;
        logic        ranked;
        logic        last;
    } t_sorted;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [2:0]  i_cfg_index = CFG_ASCENDING;
    logic [0:0]  i_cfg_data = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tlast;

    grouped_sort_and_rank_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    t_load   pending_rows[$];
    t_row    loaded_rows[$];
    t_sorted sorted_rows[$];
    t_cfg    cfg = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0};
    int      idle_mode = 0;
    int      errors = 0;
    int      cycles = 0;
    int      rows_sent = 0;
    int      rows_out = 0;
    int      data_sets = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic bit placed_later(t_row a, t_row b);
        if (cfg.use_category && a.category != b.category) return a.category > b.category;
        if (cfg.use_status && a.status != b.status) return a.status > b.status;
        if (cfg.ascending) return a.score > b.score;
        return a.score < b.score;
    endfunction

    function automatic void sort_and_rank_rows();
        t_row    order[$];
        t_row    cur;
        t_sorted res;
        int      j;
        bit      started;
        bit      pass;
        logic [7:0] grp;
        logic signed [31:0] prev_score;
        int      next_rank;
        int      step;
        int      rank;
        started = 0;
        grp = '0;
        prev_score = '0;
        next_rank = 1;
        step = 1;
        foreach (loaded_rows[i]) begin
            cur = loaded_rows[i];
            j = order.size();
            order.insert(order.size(), cur);
            while (j > 0 && placed_later(order[j - 1], cur)) begin
                order[j] = order[j - 1];
                j--;
            end
            order[j] = cur;
        end
        foreach (order[i]) begin
            cur = order[i];
            rank = 0;
            res.ranked = 1'b0;
            pass = (cur.rclass == CLASS_NONCOMP) ||
                   (cfg.keep_negative && cur.rclass == CLASS_NEG);
            if (cfg.rank_enable && !pass) begin
                if (!started || (cfg.use_category ? cur.category : 8'd0) != grp) begin
                    started = 1;
                    grp = cfg.use_category ? cur.category : 8'd0;
                    next_rank = 1;
                    step = 1;
                end else if (cur.score == prev_score) begin
                    next_rank -= step;
                    step++;
                end else begin
                    step = 1;
                end
                rank = (cfg.use_status && cur.status != 3'd0) ? -1 : next_rank;
                res.ranked = 1'b1;
                next_rank += step;
                prev_score = cur.score;
            end
            res.tag = cur.tag;
            res.category = cur.category;
            res.status = cur.status;
            res.score = cur.score;
            res.rank = rank[7:0];
            res.last = (i == order.size() - 1);
            sorted_rows.insert(sorted_rows.size(), res);
        end
        loaded_rows.delete();
        data_sets++;
    endfunction

    always @(posedge i_clk) begin
        t_load nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                rows_sent++;
                if (loaded_rows.size() < MAX_ROWS) begin
                    loaded_rows.insert(loaded_rows.size(), t_row'(s_axis_tdata[50:0]));
                end
                if (s_axis_tlast) sort_and_rank_rows();
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_rows.size() > 0 &&
                    !((idle_mode == 1 && $urandom_range(0, 99) < 61) ||
                      (idle_mode == 3 && $urandom_range(0, 99) < 9))) begin
                    nxt = pending_rows.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {5'd0, nxt.row.tag, nxt.row.rclass, nxt.row.score,
                                     nxt.row.status, nxt.row.category};
                    s_axis_tlast <= nxt.last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_sorted want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                rows_out++;
                if (sorted_rows.size() == 0) begin
                    $error("sorted row with no row waiting for output");
                    errors++;
                end else begin
                    want = sorted_rows.pop_front();
                    check_field("out_tag", want.tag, m_axis_tdata[5:0]);
                    check_field("out_category", want.category, m_axis_tdata[13:6]);
                    check_field("out_status", want.status, m_axis_tdata[16:14]);
                    check_field("out_score", $signed(want.score), $signed(m_axis_tdata[48:17]));
                    check_field("out_rank", $signed(want.rank), $signed(m_axis_tdata[56:49]));
                    check_field("out_ranked", want.ranked, m_axis_tdata[57]);
                    check_field("out_last", want.last, m_axis_tlast);
                end
            end
            m_axis_tready <= !((idle_mode == 2 && $urandom_range(0, 99) < 61) ||
                               (idle_mode == 3 && $urandom_range(0, 99) < 9));
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("grouped_sort_and_rank_core: mismatch");
            $finish;
        end
    end

    task automatic add_row(logic [7:0] cat, logic [2:0] stat, logic signed [31:0] score,
                           logic [1:0] rclass, logic [5:0] tag, logic last);
        t_load item;
        item.row.category = cat;
        item.row.status = stat;
        item.row.score = score;
        item.row.rclass = rclass;
        item.row.tag = tag;
        item.last = last;
        pending_rows.insert(pending_rows.size(), item);
    endtask

    task automatic add_random_set(int rows);
        logic [7:0] cat;
        logic [2:0] stat;
        logic signed [31:0] score;
        for (int k = 0; k < rows; k++) begin
            cat = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 3)) : 8'($urandom);
            stat = ($urandom_range(0, 9) < 7) ? 3'd0 : 3'($urandom);
            score = ($urandom_range(0, 9) < 7) ? 32'($signed($urandom_range(0, 6)) - 3)
                                                : 32'($urandom);
            add_row(cat, stat, score, 2'($urandom_range(0, 3)), 6'($urandom), k == rows - 1);
        end
    endtask

    task automatic write_reg(logic [2:0] idx, logic val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
    endtask

    task automatic wait_drained();
        while (pending_rows.size() > 0 || s_axis_tvalid || sorted_rows.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    logic [4:0] phase_cfg[8] = '{5'b11110, 5'b00000, 5'b11111, 5'b01011,
                                 5'b10110, 5'b01101, 5'b10011, 5'b01110};

    initial begin
        int count;
        int size;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int p = 0; p < 8; p++) begin
            cfg = '{phase_cfg[p][4], phase_cfg[p][3], phase_cfg[p][2], phase_cfg[p][1],
                    phase_cfg[p][0]};
            write_reg(CFG_ASCENDING, cfg.ascending);
            write_reg(CFG_USE_STAT, cfg.use_status);
            write_reg(CFG_USE_CAT, cfg.use_category);
            write_reg(CFG_RANK_EN, cfg.rank_enable);
            write_reg(CFG_KEEP_NEG, cfg.keep_negative);
            if (p == 3) write_reg(3'd6, 1'b0);
            @(posedge i_clk);
            i_cfg_wr_en <= 1'b0;
            idle_mode = p % 4;
            if (p == 0) begin
                add_row(8'd255, 3'd0, 32'sh7fffffff, 2'd0, 6'd63, 1'b0);
                add_row(8'd255, 3'd0, 32'sh7fffffff, 2'd0, 6'd1, 1'b0);
                add_row(8'd255, 3'd7, 32'sh80000000, 2'd3, 6'd0, 1'b0);
                add_row(8'd255, 3'd5, 32'sh80000000, 2'd0, 6'd2, 1'b0);
                add_row(8'd0, 3'd0, -32'sd5, 2'd1, 6'd3, 1'b0);
                add_row(8'd0, 3'd0, -32'sd5, 2'd2, 6'd4, 1'b0);
                add_row(8'd0, 3'd0, -32'sd5, 2'd0, 6'd5, 1'b0);
                add_row(8'd0, 3'd1, -32'sd5, 2'd0, 6'd6, 1'b0);
                add_row(8'd0, 3'd0, 32'sd3, 2'd0, 6'd7, 1'b0);
                add_row(8'd0, 3'd0, -32'sd5, 2'd0, 6'd8, 1'b0);
                add_row(8'd0, 3'd4, 32'sd0, 2'd3, 6'd9, 1'b1);
                add_row(8'd17, 3'd0, 32'sd0, 2'd0, 6'd42, 1'b1);
            end
            if (p == 6) add_random_set(MAX_ROWS + 2);
            count = 0;
            while (count < 16) begin
                size = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 9);
                add_random_set(size);
                count += size;
            end
            wait_drained();
        end
        $display("Sent %0d rows in %0d data sets over 8 register settings;",
                 rows_sent, data_sets);
        $display("%0d sorted rows checked.", rows_out);
        if (errors == 0) begin
            $display("grouped_sort_and_rank_core: match");
        end else begin
            $display("grouped_sort_and_rank_core: mismatch");
        end
        $finish;
    end

endmodule
